### rtl/pidff_pkg.sv
// ----------------------------------------------------------------------------
// pidff_pkg
// Shared types and register codes for the PID controller with feed-forward.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pidff_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KF_GAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_I_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT = 3'd5;

  typedef struct packed {
    logic [15:0] kp_gain;
    logic [15:0] ki_gain;
    logic [15:0] kd_gain;
    logic [15:0] kf_gain;
    logic [14:0] i_limit;
    logic [14:0] out_limit;
  } cfg_t;

  typedef struct packed {
    logic [32:0] p_prod;
    logic [32:0] i_prod;
    logic [33:0] d_prod;
    logic [31:0] f_prod;
  } prod_t;

endpackage

### rtl/pidff_term.sv
// ----------------------------------------------------------------------------
// pidff_term
// Error, error difference and the four gain products, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pidff_term
  import pidff_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  logic [15:0] target_value,
  input  logic [15:0] measured_value,
  input  cfg_t        cfg,
  output prod_t       prod
);

  logic signed [15:0] tgt;
  logic signed [15:0] meas;
  logic signed [15:0] kp;
  logic signed [15:0] ki;
  logic signed [15:0] kd;
  logic signed [15:0] kf;
  logic signed [16:0] err;
  logic signed [17:0] diff;
  logic signed [32:0] p_full;
  logic signed [32:0] i_full;
  logic signed [33:0] d_full;
  logic signed [31:0] f_full;
  logic signed [16:0] prev_err_r;
  prod_t              prod_r;

  assign tgt  = $signed(target_value);
  assign meas = $signed(measured_value);
  assign kp   = $signed(cfg.kp_gain);
  assign ki   = $signed(cfg.ki_gain);
  assign kd   = $signed(cfg.kd_gain);
  assign kf   = $signed(cfg.kf_gain);

  always_comb begin
    err    = 17'(tgt) - 17'(meas);
    diff   = 18'(err) - 18'(prev_err_r);
    p_full = 33'(kp) * 33'(err);
    i_full = 33'(ki) * 33'(err);
    d_full = 34'(kd) * 34'(diff);
    f_full = 32'(kf) * 32'(tgt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
    end else if (load) begin
      prev_err_r <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r.p_prod <= p_full;
      prod_r.i_prod <= i_full;
      prod_r.d_prod <= d_full;
      prod_r.f_prod <= f_full;
    end
  end

  assign prod = prod_r;

endmodule

### rtl/pidff_sum.sv
// ----------------------------------------------------------------------------
// pidff_sum
// Integral update with clamp, term sum and output saturation, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pidff_sum
  import pidff_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  prod_t       prod,
  input  logic [14:0] i_limit,
  input  logic [14:0] out_limit,
  output logic [15:0] drive_value
);

  logic signed [24:0] acc_r;
  logic signed [33:0] acc_sum;
  logic signed [33:0] acc_lim;
  logic signed [33:0] acc_c;
  logic signed [24:0] p_shr;
  logic signed [25:0] d_shr;
  logic signed [23:0] f_shr;
  logic signed [16:0] i_shr;
  logic signed [26:0] sum;
  logic signed [26:0] out_lim;
  logic signed [26:0] sum_c;
  logic [15:0]        drive_r;

  always_comb begin
    acc_sum = 34'(acc_r) + 34'($signed(prod.i_prod));
    acc_lim = $signed({11'b0, i_limit, 8'b0});
    if (acc_sum > acc_lim) begin
      acc_c = acc_lim;
    end else if (acc_sum < -acc_lim) begin
      acc_c = -acc_lim;
    end else begin
      acc_c = acc_sum;
    end
    p_shr   = $signed(prod.p_prod[32:8]);
    d_shr   = $signed(prod.d_prod[33:8]);
    f_shr   = $signed(prod.f_prod[31:8]);
    i_shr   = acc_c[24:8];
    sum     = 27'(p_shr) + 27'(i_shr) + 27'(d_shr) + 27'(f_shr);
    out_lim = $signed({12'b0, out_limit});
    if (sum > out_lim) begin
      sum_c = out_lim;
    end else if (sum < -out_lim) begin
      sum_c = -out_lim;
    end else begin
      sum_c = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (load) begin
      acc_r <= acc_c[24:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      drive_r <= sum_c[15:0];
    end
  end

  assign drive_value = drive_r;

endmodule

### rtl/pid_controller_with_feedforward.sv
// ----------------------------------------------------------------------------
// pid_controller_with_feedforward
// Fixed-point positional PID controller with feed-forward on the target.
//
// Input stream: one word per sample with target and measured value.
// Output stream: one word per sample with the saturated drive value.
// Configuration: write channel, index selects kp, ki, kd, kf, integral
// limit or output limit; always ready. The user must see that it is
// written between sample runs; the block does not enforce this. Pipeline:
// acceptance loads the input register, then the product and result
// registers follow, and out_tvalid shows the result register. Throughput:
// one word per cycle while out_tready is high; the integral and previous
// error each update as their stage advances. Reset: gains, limits,
// integral and previous error clear to zero and all stages empty.
// Stall: each stage holds its word while the next stage is full and held;
// empty stages keep filling, so up to three words wait inside before
// in_tready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pid_controller_with_feedforward
  import pidff_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,   // target_value[15:0], measured_value[31:16]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,  // drive_value[15:0]
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t        cfg_r;
  logic        v1_r;
  logic        v2_r;
  logic        v3_r;
  logic [15:0] tgt_r;
  logic [15:0] meas_r;
  logic        rdy1;
  logic        rdy2;
  logic        rdy3;
  logic        in_acc;
  logic        load2;
  logic        load3;
  prod_t       prod;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KP_GAIN:   cfg_r.kp_gain   <= cfg_data;
        REG_KI_GAIN:   cfg_r.ki_gain   <= cfg_data;
        REG_KD_GAIN:   cfg_r.kd_gain   <= cfg_data;
        REG_KF_GAIN:   cfg_r.kf_gain   <= cfg_data;
        REG_I_LIMIT:   cfg_r.i_limit   <= cfg_data[14:0];
        REG_OUT_LIMIT: cfg_r.out_limit <= cfg_data[14:0];
        default: begin
        end
      endcase
    end
  end

  assign rdy3      = !v3_r || out_tready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;
  assign in_acc    = in_tvalid && rdy1;
  assign load2     = v1_r && rdy2;
  assign load3     = v2_r && rdy3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (in_acc) begin
        v1_r <= 1'b1;
      end else if (load2) begin
        v1_r <= 1'b0;
      end
      if (load2) begin
        v2_r <= 1'b1;
      end else if (load3) begin
        v2_r <= 1'b0;
      end
      if (load3) begin
        v3_r <= 1'b1;
      end else if (out_tready) begin
        v3_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      tgt_r  <= in_tdata[15:0];
      meas_r <= in_tdata[31:16];
    end
  end

  pidff_term u_term (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (load2),
    .target_value   (tgt_r),
    .measured_value (meas_r),
    .cfg            (cfg_r),
    .prod           (prod)
  );

  pidff_sum u_sum (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (load3),
    .prod        (prod),
    .i_limit     (cfg_r.i_limit),
    .out_limit   (cfg_r.out_limit),
    .drive_value (out_tdata)
  );

  assign out_tvalid = v3_r;

endmodule
